>>> sv/rpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants for the range presence capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_RESTART = 2'd1;
  localparam logic [1:0] FUNC_SET_BG  = 2'd2;

  // Register map: index = paddr[ADDR_W-1:2]
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_ONE_SHOT = 2'd1;
  localparam logic [1:0] REG_HYST     = 2'd2;

  // Reset values
  localparam logic [15:0] BACKGROUND_RESET = 16'd4000;
  localparam logic [15:0] HYST_RESET       = 16'd100;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] range_mm;
    logic        read_ok;
    logic [31:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic [15:0] report_mm;
    logic [31:0] elapsed_us;
    logic        changed;
  } out_item_t;

  typedef struct packed {
    logic        enable;
    logic        one_shot_mode;
    logic [15:0] hysteresis_mm;
  } cfg_t;

endpackage

`default_nettype wire

>>> sv/rpc_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_apb_regs
// APB configuration registers: enable, one-shot mode, hysteresis.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_apb_regs
  import rpc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b0;
      cfg_q.one_shot_mode <= 1'b1;
      cfg_q.hysteresis_mm <= HYST_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:   cfg_q.enable        <= pwdata[0];
        REG_ONE_SHOT: cfg_q.one_shot_mode <= pwdata[0];
        REG_HYST:     cfg_q.hysteresis_mm <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.enable};
      REG_ONE_SHOT: prdata = {{(DATA_W-1){1'b0}}, cfg_q.one_shot_mode};
      REG_HYST:     prdata = {{(DATA_W-16){1'b0}}, cfg_q.hysteresis_mm};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/range_presence_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_presence_capture
// Gates range samples against a background, reports every gated sample with a
// change flag, or the per-pass minimum in one-shot mode, with elapsed time since restart.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                   beat
//   in        input      in_valid_i / in_ready_o     in_item_t
//   out       output     out_valid_o / out_ready_i   out_item_t
//   cfg       input      APB (psel/penable/pready)   32-bit register write
//
// One beat per cycle sustained while results are taken; a beat is held in the
// input register, then evaluated and its result loaded into the result reg.
// Beats that cause no result never wait on the output side.
// The input register stalls only while a result is pending and out is busy.
// Reset sets background 4000 mm, hysteresis 100 mm, paused, one-shot mode.
// ----------------------------------------------------------------------------
`default_nettype none

module range_presence_capture
  import rpc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  rpc_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Input register
  logic     s1_valid_q;
  in_item_t s1_item_q;

  // Block state
  logic [15:0] bg_q, bg_d;
  logic [16:0] last_q, last_d;
  logic        capt_q, capt_d;
  logic [31:0] start_q, start_d;
  logic [31:0] ctime_q, ctime_d;

  // Result register
  logic      out_valid_q;
  out_item_t out_q;

  logic      res_vld;
  out_item_t res;
  logic      adv;
  logic [16:0] bound;
  logic [16:0] rng17;
  logic [16:0] diff;
  logic        chg;
  logic        smp_ok;

  assign rng17  = {1'b0, s1_item_q.range_mm};
  assign bound  = {1'b0, bg_q} + {1'b0, cfg.hysteresis_mm};
  assign diff   = (rng17 >= last_q) ? (rng17 - last_q) : (last_q - rng17);
  assign chg    = diff >= {1'b0, cfg.hysteresis_mm};
  assign smp_ok = cfg.enable && s1_item_q.read_ok &&
                  (s1_item_q.range_mm != 16'd0) && (rng17 <= bound);

  always_comb begin
    bg_d    = bg_q;
    last_d  = last_q;
    capt_d  = capt_q;
    start_d = start_q;
    ctime_d = ctime_q;
    res_vld = 1'b0;
    res     = '0;
    case (s1_item_q.func)
      FUNC_RESTART: begin
        capt_d  = 1'b0;
        start_d = s1_item_q.time_us;
      end
      FUNC_SET_BG: begin
        if (s1_item_q.read_ok) begin
          bg_d = s1_item_q.range_mm - {cfg.hysteresis_mm[14:0], 1'b0};
        end
      end
      FUNC_SAMPLE: begin
        if (smp_ok) begin
          if (!cfg.one_shot_mode) begin
            ctime_d        = s1_item_q.time_us;
            res_vld        = 1'b1;
            res.report_mm  = s1_item_q.range_mm;
            res.elapsed_us = s1_item_q.time_us - start_q;
            res.changed    = chg;
            if (chg) begin
              last_d = rng17;
            end
          end else if (s1_item_q.range_mm < bg_q) begin
            if (capt_q) begin
              if (rng17 < last_q) begin
                last_d = rng17;
              end
            end else begin
              last_d  = rng17;
              capt_d  = 1'b1;
              ctime_d = s1_item_q.time_us;
            end
          end else if (capt_q) begin
            // object left: report the minimum seen during the pass
            capt_d         = 1'b0;
            res_vld        = 1'b1;
            res.report_mm  = last_q[15:0];
            res.elapsed_us = ctime_q - start_q;
            res.changed    = 1'b1;
            last_d         = bound;
          end
        end
      end
      default: ;
    endcase
  end

  assign adv        = s1_valid_q && (!res_vld || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q    <= BACKGROUND_RESET;
      last_q  <= '0;
      capt_q  <= 1'b0;
      start_q <= '0;
      ctime_q <= '0;
    end else if (adv) begin
      bg_q    <= bg_d;
      last_q  <= last_d;
      capt_q  <= capt_d;
      start_q <= start_d;
      ctime_q <= ctime_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res_vld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_item_q.func == FUNC_RESTART) |=>
      (start_q == $past(s1_item_q.time_us)) && !capt_q)
    else $error("restart did not record start time");

  a_res_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_vld) |=> out_valid_q)
    else $error("result beat lost");

  a_one_shot_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_vld && cfg.one_shot_mode) |=> (out_q.changed && !capt_q))
    else $error("one-shot report without flag or capture still open");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(adv && res_vld))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
